>>> sv/ble_lamp_command_packet_builder_defines.svh
// Shared assertion macros for the lamp frame builder checks.
`ifndef BLE_LAMP_COMMAND_PACKET_BUILDER_DEFINES_SVH
`define BLE_LAMP_COMMAND_PACKET_BUILDER_DEFINES_SVH

// Check a consequent in the same cycle as the antecedent.
`define BLCPB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("blcpb check failed");

// Check a consequent in the cycle after the antecedent.
`define BLCPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("blcpb check failed");

`endif

>>> sv/blcpb_pkg.sv
package blcpb_pkg;

  localparam int FRAME_BYTES = 31;
  localparam int HDR_LEN     = 7;
  localparam int BODY_BYTES  = FRAME_BYTES - HDR_LEN;
  localparam int FIXED_BYTES = 15;
  localparam int IDX_W       = $clog2(FRAME_BYTES + 1);
  localparam int FIX_IDX_W   = $clog2(FIXED_BYTES);
  localparam int BODY_IDX_W  = $clog2(BODY_BYTES);
  localparam int WHITEN_SKIP = 15;

  typedef logic [7:0]       byte_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] GROUP_MASK  = 16'hF0FF;
  localparam logic [15:0] SEED_MOD    = 16'd65525;
  localparam byte_t       RGB_CMD     = 8'h22;
  localparam byte_t       WHITEN_SEED = 8'd83;
  localparam byte_t       WHITEN_TAPS = 8'h11;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROLLER_ID = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_INDEX   = 4'd1;

  // Advertising header followed by protocol header
  localparam byte_t FIXED_HDR [FIXED_BYTES] = '{
    8'h02, 8'h01, 8'h02, 8'h1B, 8'h03, 8'h77, 8'hF8,
    8'hAA, 8'h98, 8'h43, 8'hAF, 8'h0B, 8'h46, 8'h46, 8'h46
  };

  // Frame positions of the variable bytes
  localparam idx_t POS_CMD      = 5'd15;
  localparam idx_t POS_GRP_LO   = 5'd16;
  localparam idx_t POS_GRP_HI   = 5'd17;
  localparam idx_t POS_ARG1     = 5'd18;
  localparam idx_t POS_ARG2     = 5'd19;
  localparam idx_t POS_ARG3     = 5'd20;
  localparam idx_t POS_TXCNT    = 5'd21;
  localparam idx_t POS_PARAM    = 5'd22;
  localparam idx_t POS_SEEDX_A  = 5'd23;
  localparam idx_t POS_SEEDX_B  = 5'd24;
  localparam idx_t POS_SEED_HI  = 5'd25;
  localparam idx_t POS_SEED_LO  = 5'd26;
  localparam idx_t POS_INNER_HI = 5'd27;
  localparam idx_t POS_INNER_LO = 5'd28;
  localparam idx_t POS_OUTER_HI = 5'd29;
  localparam idx_t POS_OUTER_LO = 5'd30;

  typedef struct packed {
    byte_t       command_code;
    byte_t       command_param;
    byte_t       first_arg;
    byte_t       second_arg;
    byte_t       third_arg;
    logic [15:0] random_seed;
  } cmd_t;

  typedef struct packed {
    logic  we;
    idx_t  addr;
    byte_t data;
    idx_t  fill;
  } ram_wr_t;

  // One byte of CRC16-CCITT, MSB first
  function automatic logic [15:0] crc_byte(logic [15:0] acc, byte_t d);
    logic [15:0] c;
    c = acc ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic byte_t flip8(byte_t v);
    byte_t r;
    for (int b = 0; b < 8; b++) begin
      r[7-b] = v[b];
    end
    return r;
  endfunction

  // CRC over protocol header bytes 1..5
  function automatic logic [15:0] gen_proto_crc();
    logic [15:0] c;
    c = CRC_INIT;
    for (int i = 1; i <= 5; i++) begin
      c = crc_byte(c, FIXED_HDR[HDR_LEN+i]);
    end
    return c;
  endfunction

  localparam logic [15:0] PROTO_CRC_INIT = gen_proto_crc();

  typedef byte_t mask_tbl_t [BODY_BYTES];

  // Whitening stream, leading bytes dropped
  function automatic mask_tbl_t gen_whiten();
    mask_tbl_t t;
    byte_t     lfsr;
    byte_t     m;
    lfsr = WHITEN_SEED;
    for (int i = 0; i < WHITEN_SKIP + BODY_BYTES; i++) begin
      m = '0;
      for (int b = 0; b < 8; b++) begin
        lfsr = {lfsr[6:0], 1'b0};
        if (lfsr[7]) begin
          lfsr = lfsr ^ WHITEN_TAPS;
          m[b] = 1'b1;
        end
        lfsr[7] = 1'b0;
      end
      if (i >= WHITEN_SKIP) begin
        t[i-WHITEN_SKIP] = m;
      end
    end
    return t;
  endfunction

  localparam mask_tbl_t WHITEN_MASK = gen_whiten();

endpackage

>>> sv/blcpb_if.sv
interface blcpb_cmd_if;
  logic        valid;
  logic        ready;
  logic [7:0]  command_code;
  logic [7:0]  command_param;
  logic [7:0]  first_arg;
  logic [7:0]  second_arg;
  logic [7:0]  third_arg;
  logic [15:0] random_seed;

  modport source (
    output valid, command_code, command_param, first_arg, second_arg, third_arg,
           random_seed,
    input  ready
  );
  modport sink (
    input  valid, command_code, command_param, first_arg, second_arg, third_arg,
           random_seed,
    output ready
  );
endinterface

interface blcpb_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [4:0] byte_index;
  logic       last_byte;

  modport source (output valid, frame_byte, byte_index, last_byte, input ready);
  modport sink (input valid, frame_byte, byte_index, last_byte, output ready);
endinterface

>>> sv/blcpb_builder.sv
module blcpb_builder (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  blcpb_pkg::cmd_t        cmd_i,
  input  logic [15:0]            controller_id_i,
  input  logic [3:0]             group_index_i,
  output blcpb_pkg::ram_wr_t     wr_o,
  output logic                   idle_o
);

  blcpb_pkg::idx_t  wr_cnt_q, wr_cnt_d;
  blcpb_pkg::byte_t tx_q, tx_d, tx_inc;
  blcpb_pkg::byte_t code_q, param_q, arg1_q, arg2_q, arg3_q;
  logic [15:0]      seed_q, grp_q, inner_q, outer_q;
  logic [15:0]      seed_red, inner_d, outer_d;
  blcpb_pkg::byte_t raw, stored;
  logic             wr_active, in_inner, in_outer;
  logic [blcpb_pkg::BODY_IDX_W-1:0] body_idx;

  assign wr_active = (wr_cnt_q < blcpb_pkg::idx_t'(blcpb_pkg::FRAME_BYTES));
  assign idle_o    = !wr_active;

  // Advance the transmit counter, skipping zero
  assign tx_inc = tx_q + 8'd1;
  assign tx_d   = (tx_inc == 8'd0) ? 8'd1 : tx_inc;

  // Fold the seed back into range
  assign seed_red = (cmd_i.random_seed >= blcpb_pkg::SEED_MOD)
                  ? (cmd_i.random_seed - blcpb_pkg::SEED_MOD) : cmd_i.random_seed;

  always_comb begin
    wr_cnt_d = wr_cnt_q;
    if (start_i) begin
      wr_cnt_d = '0;
    end else if (wr_active) begin
      wr_cnt_d = wr_cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_cnt_q <= blcpb_pkg::idx_t'(blcpb_pkg::FRAME_BYTES);
      tx_q     <= '0;
    end else begin
      wr_cnt_q <= wr_cnt_d;
      if (start_i) begin
        tx_q <= tx_d;
      end
    end
  end

  // Raw byte for the current write position
  always_comb begin
    case (wr_cnt_q)
      blcpb_pkg::POS_CMD:      raw = code_q;
      blcpb_pkg::POS_GRP_LO:   raw = grp_q[7:0];
      blcpb_pkg::POS_GRP_HI:   raw = grp_q[15:8];
      blcpb_pkg::POS_ARG1:     raw = arg1_q;
      blcpb_pkg::POS_ARG2:     raw = arg2_q;
      blcpb_pkg::POS_ARG3:     raw = arg3_q;
      blcpb_pkg::POS_TXCNT:    raw = tx_q;
      blcpb_pkg::POS_PARAM:    raw = param_q;
      blcpb_pkg::POS_SEEDX_A,
      blcpb_pkg::POS_SEEDX_B:  raw = seed_q[7:0] ^ 8'h01;
      blcpb_pkg::POS_SEED_HI:  raw = seed_q[15:8];
      blcpb_pkg::POS_SEED_LO:  raw = seed_q[7:0];
      blcpb_pkg::POS_INNER_HI: raw = inner_q[15:8];
      blcpb_pkg::POS_INNER_LO: raw = inner_q[7:0];
      blcpb_pkg::POS_OUTER_HI: raw = outer_q[15:8];
      blcpb_pkg::POS_OUTER_LO: raw = outer_q[7:0];
      default:                 raw = blcpb_pkg::FIXED_HDR[wr_cnt_q[blcpb_pkg::FIX_IDX_W-1:0]];
    endcase
  end

  // Run the inner CRC over the command body and the outer CRC over the body and inner CRC, one byte a cycle
  assign in_inner = wr_active && (wr_cnt_q >= blcpb_pkg::POS_CMD)
                  && (wr_cnt_q <= blcpb_pkg::POS_SEED_LO);
  assign in_outer = wr_active && (wr_cnt_q >= blcpb_pkg::POS_CMD)
                  && (wr_cnt_q <= blcpb_pkg::POS_INNER_LO);
  assign inner_d  = blcpb_pkg::crc_byte(inner_q, raw);
  assign outer_d  = blcpb_pkg::crc_byte(outer_q, raw);

  // Bit-reverse and whiten everything after the advertising header
  assign body_idx = blcpb_pkg::BODY_IDX_W'(wr_cnt_q - blcpb_pkg::idx_t'(blcpb_pkg::HDR_LEN));
  assign stored   = (wr_cnt_q >= blcpb_pkg::idx_t'(blcpb_pkg::HDR_LEN))
                  ? (blcpb_pkg::flip8(raw) ^ blcpb_pkg::WHITEN_MASK[body_idx]) : raw;

  // Capture the request and hold the running CRCs
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      code_q  <= cmd_i.command_code;
      param_q <= cmd_i.command_param;
      arg1_q  <= cmd_i.first_arg;
      arg2_q  <= cmd_i.second_arg;
      arg3_q  <= (cmd_i.command_code == blcpb_pkg::RGB_CMD) ? cmd_i.third_arg : 8'h00;
      seed_q  <= seed_red;
      grp_q   <= (controller_id_i & blcpb_pkg::GROUP_MASK) | {4'h0, group_index_i, 8'h00};
      inner_q <= ~seed_red;
      outer_q <= blcpb_pkg::PROTO_CRC_INIT;
    end else begin
      if (in_inner) begin
        inner_q <= inner_d;
      end
      if (in_outer) begin
        outer_q <= outer_d;
      end
    end
  end

  assign wr_o.we   = wr_active;
  assign wr_o.addr = wr_cnt_q;
  assign wr_o.data = stored;
  assign wr_o.fill = wr_cnt_q;

endmodule

>>> sv/blcpb_streamer.sv
module blcpb_streamer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  blcpb_pkg::ram_wr_t         wr_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output blcpb_pkg::byte_t           frame_byte_o,
  output blcpb_pkg::idx_t            byte_index_o,
  output logic                       last_byte_o,
  output logic                       rd_done_o
);

  blcpb_pkg::byte_t mem [blcpb_pkg::FRAME_BYTES];
  blcpb_pkg::byte_t rdata_q;
  blcpb_pkg::idx_t  rd_cnt_q, idx_q;
  logic             pend_q, rd_en;

  assign rd_done_o = (rd_cnt_q == blcpb_pkg::idx_t'(blcpb_pkg::FRAME_BYTES));

  // Read only bytes already written; hold while the output register is stalled
  assign rd_en = (rd_cnt_q < wr_i.fill) && (!pend_q || out_ready_i);

  // Frame RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_cnt_q];
      idx_q   <= rd_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q <= blcpb_pkg::idx_t'(blcpb_pkg::FRAME_BYTES);
      pend_q   <= 1'b0;
    end else begin
      if (start_i) begin
        rd_cnt_q <= '0;
      end else if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + 5'd1;
      end
      if (rd_en) begin
        pend_q <= 1'b1;
      end else if (out_ready_i) begin
        pend_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = pend_q;
  assign frame_byte_o = rdata_q;
  assign byte_index_o = idx_q;
  assign last_byte_o  = (idx_q == blcpb_pkg::idx_t'(blcpb_pkg::FRAME_BYTES - 1));

endmodule

>>> sv/ble_lamp_command_packet_builder.sv
// Lamp command frame builder. Each accepted command request yields a 31-byte
// advertising frame, streamed one byte per result request, byte 0 first, with
// byte_index and last_byte alongside. The builder writes the finished frame into
// a 31-byte frame RAM one byte per cycle, running the inner and outer CRC16 and
// the bit-reverse/whitening on the way, and the output side reads that RAM
// behind the writer through a registered read port. The next command is taken
// in the cycle after the read of the final byte has been issued, so a new frame
// cannot start before the last one has been read out of the RAM. Output stalls
// hold the read side and so delay the next command. The frame RAM needs no
// clearing after reset. Configuration writes are taken any cycle but must only
// happen while no frame is in flight.
module ble_lamp_command_packet_builder (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  blcpb_cmd_if.sink                              cmd_i,
  blcpb_frame_if.source                          frame_o,
  input  logic                                   cfg_we_i,
  input  logic [blcpb_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [blcpb_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  logic [15:0]        controller_id_q;
  logic [3:0]         group_index_q;
  blcpb_pkg::cmd_t    cmd;
  blcpb_pkg::ram_wr_t wr;
  logic               start, build_idle, rd_done;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      controller_id_q <= '0;
      group_index_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        blcpb_pkg::REG_CONTROLLER_ID: controller_id_q <= cfg_data_i[15:0];
        blcpb_pkg::REG_GROUP_INDEX:   group_index_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Take a new request once the previous frame is fully read out of the RAM
  assign cmd_i.ready = build_idle && rd_done;
  assign start       = cmd_i.valid && cmd_i.ready;

  assign cmd.command_code  = cmd_i.command_code;
  assign cmd.command_param = cmd_i.command_param;
  assign cmd.first_arg     = cmd_i.first_arg;
  assign cmd.second_arg    = cmd_i.second_arg;
  assign cmd.third_arg     = cmd_i.third_arg;
  assign cmd.random_seed   = cmd_i.random_seed;

  blcpb_builder u_builder (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .cmd_i           (cmd),
    .controller_id_i (controller_id_q),
    .group_index_i   (group_index_q),
    .wr_o            (wr),
    .idle_o          (build_idle)
  );

  blcpb_streamer u_streamer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .wr_i         (wr),
    .out_ready_i  (frame_o.ready),
    .out_valid_o  (frame_o.valid),
    .frame_byte_o (frame_o.frame_byte),
    .byte_index_o (frame_o.byte_index),
    .last_byte_o  (frame_o.last_byte),
    .rd_done_o    (rd_done)
  );

endmodule

>>> sv/blcpb_checker.sv
`include "ble_lamp_command_packet_builder_defines.svh"

module blcpb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cmd_valid_i,
  input logic       cmd_ready_i,
  input logic       frm_valid_i,
  input logic       frm_ready_i,
  input logic [7:0] frm_byte_i,
  input logic [4:0] frm_index_i,
  input logic       frm_last_i
);

  // Last flag marks the final frame position only
  `BLCPB_ASSERT_NOW(a_last_index, frm_valid_i && frm_last_i, frm_index_i == 5'd30)

  // A frame in flight blocks new command requests
  `BLCPB_ASSERT_NEXT(a_busy_after_cmd, cmd_valid_i && cmd_ready_i, !cmd_ready_i)

  // No new command before the final byte is on the output
  `BLCPB_ASSERT_NOW(a_no_cmd_mid_frame, frm_valid_i && !frm_last_i, !cmd_ready_i)

  // Bytes of one frame come out in order
  `BLCPB_ASSERT_NEXT(a_index_step, frm_valid_i && frm_ready_i && !frm_last_i, !frm_valid_i || (frm_index_i == $past(frm_index_i) + 5'd1))

  // Stalled result request holds its byte
  `BLCPB_ASSERT_NEXT(a_hold_stall, frm_valid_i && !frm_ready_i, frm_valid_i && $stable(frm_byte_i))

endmodule

bind ble_lamp_command_packet_builder blcpb_checker u_blcpb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .frm_valid_i (frame_o.valid),
  .frm_ready_i (frame_o.ready),
  .frm_byte_i  (frame_o.frame_byte),
  .frm_index_i (frame_o.byte_index),
  .frm_last_i  (frame_o.last_byte)
);
